>>> rtl/core/scg_pkg.sv
`timescale 1ns / 1ps

package scg_pkg;

   // History geometry.
   localparam int HIST_DEPTH = 16;
   localparam int ADDR_W     = $clog2(HIST_DEPTH);
   localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

   // Field widths.
   localparam int TIME_W  = 48;
   localparam int ANGLE_W = 16;
   localparam int RATE_W  = 32;
   localparam int DIFF_W  = RATE_W + 1;
   localparam int NUM_W   = 54;
   localparam int DEN_W   = TIME_W + 1;
   localparam int QUO_W   = NUM_W + 1;
   localparam int CSR_W   = 31;
   localparam int CSR_IDX_W = 3;

   localparam longint unsigned US_PER_S = 64'd1000000;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN       = 3'd0,
      CSR_MAX_AGE    = 3'd1,
      CSR_PATIENCE   = 3'd2,
      CSR_ERR_THRESH = 3'd3,
      CSR_RATE_THRESH = 3'd4
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [15:0] GAIN_RST        = 16'd5571;
   localparam logic [23:0] MAX_AGE_RST     = 24'd1000000;
   localparam logic [23:0] PATIENCE_RST    = 24'd100000;
   localparam logic [14:0] ERR_THRESH_RST  = 15'd41;
   localparam logic [30:0] RATE_THRESH_RST = 31'd70;

   // One history entry.
   typedef struct packed {
      logic [TIME_W-1:0]         time_us;
      logic signed [ANGLE_W-1:0] err;
      logic signed [RATE_W-1:0]  rate;
   } hist_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_ev;
      logic aged;
      logic mul;
      logic div_start;
      logic rate_done;
      logic jerk_done;
      logic sh_init;
      logic sh_wr;
      logic sh_end;
      logic write_new;
      logic out_load;
   } scg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_end;
      logic need_div;
      logic div_done;
      logic full;
      logic sh_end;
   } scg_status_type;

   // Saturate a quotient to the 32 bit signed range.
   function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [QUO_W-1:0] v);
      logic signed [QUO_W-1:0] hi;
      logic signed [QUO_W-1:0] lo;
      hi = QUO_W'(64'sh7FFFFFFF);
      lo = -QUO_W'(64'sh80000000);
      if (v > hi) begin
         return RATE_W'(hi);
      end else if (v < lo) begin
         return RATE_W'(lo);
      end
      return RATE_W'(v);
   endfunction

endpackage

>>> rtl/core/scg_req_if.sv
`timescale 1ns / 1ps

interface scg_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [scg_pkg::TIME_W-1:0]               sample_time_us;
   logic [scg_pkg::TIME_W-1:0]               now_us;
   logic signed [scg_pkg::ANGLE_W-1:0]       desired_azimuth;
   logic signed [scg_pkg::ANGLE_W-1:0]       actual_azimuth;

   modport source (output valid, sample_time_us, now_us, desired_azimuth, actual_azimuth,
                   input ready);
   modport sink (input valid, sample_time_us, now_us, desired_azimuth, actual_azimuth,
                 output ready);
endinterface

>>> rtl/core/scg_rsp_if.sv
`timescale 1ns / 1ps

interface scg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                send_correction;
   logic signed [scg_pkg::ANGLE_W-1:0]  amplitude;
   logic signed [scg_pkg::ANGLE_W-1:0]  heading_error;
   logic signed [scg_pkg::RATE_W-1:0]   error_rate;
   logic signed [scg_pkg::RATE_W-1:0]   error_jerk;
   logic                                rate_fault;

   modport source (output valid, send_correction, amplitude, heading_error, error_rate,
                   error_jerk, rate_fault, input ready);
   modport sink (input valid, send_correction, amplitude, heading_error, error_rate,
                 error_jerk, rate_fault, output ready);
endinterface

>>> rtl/core/steering_correction_gate.sv
`timescale 1ns / 1ps

// Heading-error steering gate. One heading sample is taken at a time; the next is taken once
// the result of the previous one sits in the output register, which holds it until the sink
// takes the transfer. An item goes through the accept step, the history scan, the aging step,
// the store and the finish. Two serial divides, one quotient bit per cycle, follow the aging
// step when the oldest kept entry gives a positive time difference, and the oldest entry of a
// full history is dropped before the store. The finish waits for a free output register.
module steering_correction_gate (
   input  logic                           clock,
   input  logic                           reset,
   scg_req_if.sink                        req_chan,
   scg_rsp_if.source                      rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [scg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [scg_pkg::CSR_W-1:0]      csr_write_data
);

   scg_pkg::scg_cmd_type    cmd;
   scg_pkg::scg_status_type status;

   scg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   scg_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

`ifndef SYNTHESIS
   // One item at a time: a transfer in closes the input for the next cycle.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("input taken while an item is in work");

   // A fault forces rate and jerk to zero.
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.rate_fault) |->
         (rsp_chan.error_rate == '0 && rsp_chan.error_jerk == '0))
      else $error("fault with nonzero rate or jerk");

   // No correction means no amplitude.
   a_amp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.send_correction) |-> rsp_chan.amplitude == '0)
      else $error("amplitude without correction");
`endif

endmodule

>>> rtl/core/scg_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, truncating toward zero.
module scg_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [scg_pkg::NUM_W-1:0]  num,
   input  logic [scg_pkg::DEN_W-1:0]         den,
   output logic                              done,
   output logic signed [scg_pkg::QUO_W-1:0]  quo
);

   localparam int STEP_W = $clog2(scg_pkg::NUM_W + 1);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic [scg_pkg::DEN_W-1:0]    rem_ff, rem_in;
   logic [scg_pkg::NUM_W-1:0]    q_ff, q_in;
   logic [scg_pkg::DEN_W-1:0]    den_ff, den_in;
   logic                         neg_ff, neg_in;
   logic [scg_pkg::DEN_W:0]      trial;

   // One shift and trial subtract per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, q_ff[scg_pkg::NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         q_in    = num[scg_pkg::NUM_W-1] ? scg_pkg::NUM_W'(-num) : scg_pkg::NUM_W'(num);
         den_in  = den;
         neg_in  = num[scg_pkg::NUM_W-1];
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = scg_pkg::DEN_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[scg_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = scg_pkg::DEN_W'(trial);
            q_in   = {q_ff[scg_pkg::NUM_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(scg_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});

endmodule

>>> rtl/core/scg_dp.sv
`timescale 1ns / 1ps

module scg_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  scg_pkg::scg_cmd_type              cmd,
   output scg_pkg::scg_status_type           status,
   input  logic                              csr_write_enable,
   input  logic [scg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [scg_pkg::CSR_W-1:0]         csr_write_data,
   scg_req_if.sink                           req_chan,
   scg_rsp_if.source                         rsp_chan
);

   // Configuration registers.
   logic [15:0] gain_ff;
   logic [23:0] max_age_ff;
   logic [23:0] patience_ff;
   logic [14:0] err_thresh_ff;
   logic [30:0] rate_thresh_ff;

   // Item registers.
   logic [scg_pkg::TIME_W-1:0]         ts_ff, now_ff, last_corr_ff;
   logic signed [scg_pkg::ANGLE_W-1:0] err_ff;
   logic [scg_pkg::CNT_W-1:0]          cnt_ff, idx_ff, keep_ff;
   scg_pkg::hist_entry_type            first_ff, rd_data_ff;
   logic signed [scg_pkg::DIFF_W-1:0]  diff_ff;
   logic signed [scg_pkg::NUM_W-1:0]   num_ff;
   logic [scg_pkg::DEN_W-1:0]          dt_ff;
   logic signed [scg_pkg::RATE_W-1:0]  rate_ff, jerk_ff;
   logic                               fault_ff;
   logic signed [32:0]                 prod_ff;

   // Output payload registers.
   logic                               o_send_ff;
   logic signed [scg_pkg::ANGLE_W-1:0] o_amp_ff, o_err_ff;
   logic signed [scg_pkg::RATE_W-1:0]  o_rate_ff, o_jerk_ff;
   logic                               o_fault_ff;

   scg_pkg::hist_entry_type            mem [scg_pkg::HIST_DEPTH];
   logic                               mem_we;
   logic [scg_pkg::ADDR_W-1:0]         mem_waddr;
   scg_pkg::hist_entry_type            mem_wdata;

   logic signed [scg_pkg::ANGLE_W:0]   err_raw;
   logic signed [scg_pkg::ANGLE_W-1:0] err_sat;
   logic signed [scg_pkg::TIME_W:0]    age, dt_w, since;
   logic                               keep_it, dt_pos;
   logic                               div_done;
   logic signed [scg_pkg::QUO_W-1:0]   quo;
   logic signed [scg_pkg::RATE_W-1:0]  quo_sat;
   logic [scg_pkg::RATE_W:0]           rate_abs;
   logic [scg_pkg::ANGLE_W-1:0]        err_abs;
   logic                               patient, zero_rate, helping, send;
   logic [32:0]                        p_abs;
   logic [33:0]                        p_rnd;
   logic signed [19:0]                 amp_s;
   logic signed [scg_pkg::ANGLE_W-1:0] amp_sat;

   // Heading error, saturated to 16 bits.
   always_comb begin
      err_raw = $signed({req_chan.desired_azimuth[15], req_chan.desired_azimuth})
              - $signed({req_chan.actual_azimuth[15], req_chan.actual_azimuth});
      if (err_raw > 17'sd32767) begin
         err_sat = 16'sh7FFF;
      end else if (err_raw < -17'sd32768) begin
         err_sat = 16'sh8000;
      end else begin
         err_sat = err_raw[15:0];
      end
   end

   // Age test and time difference against the oldest kept entry.
   assign age     = $signed({1'b0, now_ff}) - $signed({1'b0, rd_data_ff.time_us});
   assign keep_it = age < $signed({25'd0, max_age_ff});
   assign dt_w    = $signed({1'b0, ts_ff}) - $signed({1'b0, first_ff.time_us});
   assign dt_pos  = !dt_w[scg_pkg::TIME_W] && (dt_w != '0);

   scg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (dt_ff),
      .done  (div_done),
      .quo   (quo)
   );

   assign quo_sat = scg_pkg::sat_rate(quo);

   // Correction decision and rounded amplitude.
   always_comb begin
      since     = $signed({1'b0, now_ff}) - $signed({1'b0, last_corr_ff});
      patient   = since < $signed({25'd0, patience_ff});
      err_abs   = err_ff[15] ? 16'(-err_ff) : 16'(err_ff);
      rate_abs  = rate_ff[31] ? 33'(-$signed({rate_ff[31], rate_ff}))
                              : 33'({rate_ff[31], rate_ff});
      zero_rate = rate_abs < {2'd0, rate_thresh_ff};
      helping   = err_ff[15] != rate_ff[31];
      send      = !patient && (err_abs > {1'b0, err_thresh_ff}) && (zero_rate || !helping);
      p_abs     = prod_ff[32] ? 33'(-prod_ff) : 33'(prod_ff);
      p_rnd     = {1'b0, p_abs} + 34'd16384;
      amp_s     = prod_ff[32] ? -$signed({1'b0, p_rnd[33:15]}) : $signed({1'b0, p_rnd[33:15]});
      if (amp_s > 20'sd32767) begin
         amp_sat = 16'sh7FFF;
      end else if (amp_s < -20'sd32768) begin
         amp_sat = 16'sh8000;
      end else begin
         amp_sat = amp_s[15:0];
      end
   end

   // History write port.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = keep_ff[scg_pkg::ADDR_W-1:0];
      mem_wdata = rd_data_ff;
      if (cmd.scan_ev) begin
         mem_we = keep_it;
      end else if (cmd.sh_wr) begin
         mem_we    = 1'b1;
         mem_waddr = scg_pkg::ADDR_W'(idx_ff - 1'b1);
      end else if (cmd.write_new) begin
         mem_we    = 1'b1;
         mem_waddr = cnt_ff[scg_pkg::ADDR_W-1:0];
         mem_wdata = '{time_us: ts_ff, err: err_ff, rate: rate_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[idx_ff[scg_pkg::ADDR_W-1:0]];
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff        <= scg_pkg::GAIN_RST;
         max_age_ff     <= scg_pkg::MAX_AGE_RST;
         patience_ff    <= scg_pkg::PATIENCE_RST;
         err_thresh_ff  <= scg_pkg::ERR_THRESH_RST;
         rate_thresh_ff <= scg_pkg::RATE_THRESH_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            scg_pkg::CSR_GAIN:        gain_ff        <= csr_write_data[15:0];
            scg_pkg::CSR_MAX_AGE:     max_age_ff     <= csr_write_data[23:0];
            scg_pkg::CSR_PATIENCE:    patience_ff    <= csr_write_data[23:0];
            scg_pkg::CSR_ERR_THRESH:  err_thresh_ff  <= csr_write_data[14:0];
            scg_pkg::CSR_RATE_THRESH: rate_thresh_ff <= csr_write_data[30:0];
            default: ;
         endcase
      end
   end

   // History count and correction time.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         last_corr_ff <= '0;
      end else begin
         if (cmd.aged) begin
            cnt_ff <= keep_ff;
         end else if (cmd.sh_end) begin
            cnt_ff <= scg_pkg::CNT_W'(scg_pkg::HIST_DEPTH - 1);
         end else if (cmd.write_new) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.out_load && send) begin
            last_corr_ff <= now_ff;
         end
      end
   end

   // Item datapath.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ts_ff   <= req_chan.sample_time_us;
         now_ff  <= req_chan.now_us;
         err_ff  <= err_sat;
         idx_ff  <= '0;
         keep_ff <= '0;
      end
      if (cmd.scan_ev) begin
         idx_ff <= idx_ff + 1'b1;
         if (keep_it) begin
            keep_ff <= keep_ff + 1'b1;
            if (keep_ff == '0) begin
               first_ff <= rd_data_ff;
            end
         end
      end
      if (cmd.aged) begin
         rate_ff  <= '0;
         jerk_ff  <= '0;
         fault_ff <= (keep_ff != '0) && !dt_pos;
         dt_ff    <= scg_pkg::DEN_W'(dt_w);
         diff_ff  <= scg_pkg::DIFF_W'(err_ff) - scg_pkg::DIFF_W'(first_ff.err);
      end
      if (cmd.mul) begin
         num_ff <= scg_pkg::NUM_W'(diff_ff) * $signed(scg_pkg::NUM_W'(scg_pkg::US_PER_S));
      end
      if (cmd.rate_done) begin
         rate_ff <= quo_sat;
         diff_ff <= scg_pkg::DIFF_W'(quo_sat) - scg_pkg::DIFF_W'(first_ff.rate);
      end
      if (cmd.jerk_done) begin
         jerk_ff <= quo_sat;
      end
      if (cmd.sh_init) begin
         idx_ff <= scg_pkg::CNT_W'(1);
      end
      if (cmd.sh_wr) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.write_new) begin
         prod_ff <= $signed({1'b0, gain_ff}) * err_ff;
      end
      if (cmd.out_load) begin
         o_send_ff  <= send;
         o_amp_ff   <= send ? amp_sat : '0;
         o_err_ff   <= err_ff;
         o_rate_ff  <= rate_ff;
         o_jerk_ff  <= jerk_ff;
         o_fault_ff <= fault_ff;
      end
   end

   assign status.scan_end = idx_ff == cnt_ff;
   assign status.need_div = (keep_ff != '0) && dt_pos;
   assign status.div_done = div_done;
   assign status.full     = cnt_ff == scg_pkg::CNT_W'(scg_pkg::HIST_DEPTH);
   assign status.sh_end   = idx_ff == scg_pkg::CNT_W'(scg_pkg::HIST_DEPTH);

   assign rsp_chan.send_correction = o_send_ff;
   assign rsp_chan.amplitude       = o_amp_ff;
   assign rsp_chan.heading_error   = o_err_ff;
   assign rsp_chan.error_rate      = o_rate_ff;
   assign rsp_chan.error_jerk      = o_jerk_ff;
   assign rsp_chan.rate_fault      = o_fault_ff;

endmodule

>>> rtl/core/scg_ctrl.sv
`timescale 1ns / 1ps

module scg_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  scg_pkg::scg_status_type  status,
   output scg_pkg::scg_cmd_type     cmd
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_SCAN_RD, ST_SCAN_EV, ST_AGED,
      ST_MUL_R, ST_DIVS_R, ST_DIVW_R, ST_RATE,
      ST_MUL_J, ST_DIVS_J, ST_DIVW_J, ST_JERK,
      ST_SH_CHK, ST_SH_RD, ST_SH_WR, ST_WRITE, ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: state_in = status.scan_end ? ST_AGED : ST_SCAN_EV;
         ST_SCAN_EV: begin
            cmd.scan_ev = 1'b1;
            state_in    = ST_SCAN_RD;
         end
         ST_AGED: begin
            cmd.aged = 1'b1;
            state_in = status.need_div ? ST_MUL_R : ST_SH_CHK;
         end
         ST_MUL_R: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIVS_R;
         end
         ST_DIVS_R: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVW_R;
         end
         ST_DIVW_R: state_in = status.div_done ? ST_RATE : ST_DIVW_R;
         ST_RATE: begin
            cmd.rate_done = 1'b1;
            state_in      = ST_MUL_J;
         end
         ST_MUL_J: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIVS_J;
         end
         ST_DIVS_J: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVW_J;
         end
         ST_DIVW_J: state_in = status.div_done ? ST_JERK : ST_DIVW_J;
         ST_JERK: begin
            cmd.jerk_done = 1'b1;
            state_in      = ST_SH_CHK;
         end
         ST_SH_CHK: begin
            if (status.full) begin
               cmd.sh_init = 1'b1;
               state_in    = ST_SH_RD;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_SH_RD: begin
            if (status.sh_end) begin
               cmd.sh_end = 1'b1;
               state_in   = ST_WRITE;
            end else begin
               state_in = ST_SH_WR;
            end
         end
         ST_SH_WR: begin
            cmd.sh_wr = 1'b1;
            state_in  = ST_SH_RD;
         end
         ST_WRITE: begin
            cmd.write_new = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> bench/scg_checker.sv
`timescale 1ns / 1ps

// Watches the heading and result channels, keeps its own copy of the gate's
// history and settings, and checks every result transfer against the oldest
// outstanding prediction.
module scg_checker
   import scg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   scg_req_if                   req,
   scg_rsp_if                   rsp,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data,
   output int                   fail_count,
   output int                   pending_results,
   output int                   correction_count,
   output int                   fault_count
);

   typedef struct {
      bit                        send;
      logic signed [ANGLE_W-1:0] amp;
      logic signed [ANGLE_W-1:0] err;
      logic signed [RATE_W-1:0]  rate;
      logic signed [RATE_W-1:0]  jerk;
      bit                        fault;
   } steer_result_type;

   steer_result_type awaited_steer[$];

   // Shadow copy of the history, oldest entry in slot 0.
   longint hist_stamp [HIST_DEPTH];
   longint hist_err   [HIST_DEPTH];
   longint hist_rate  [HIST_DEPTH];
   int     kept_entries;
   longint last_fix_us;

   // Shadow copy of the settings.
   longint gain_q15;
   longint max_age;
   longint patience;
   longint err_thresh;
   longint rate_thresh;

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // Work out the result of one heading sample and advance the shadow state.
   task automatic predict_heading(input longint ts, input longint now,
                                  input longint desired, input longint actual);
      steer_result_type res;
      int               survivors;
      longint           err;
      longint           rate;
      longint           jerk;
      longint           dt;
      longint           prod;
      longint           rounded;
      bit               zero_rate;
      bit               helping;
      res = '{default: 0};
      rate = 0;
      jerk = 0;

      // Drop aged entries and compact, keeping order.
      survivors = 0;
      for (int i = 0; i < kept_entries; i++) begin
         if (now - hist_stamp[i] < max_age) begin
            hist_stamp[survivors] = hist_stamp[i];
            hist_err[survivors]   = hist_err[i];
            hist_rate[survivors]  = hist_rate[i];
            survivors++;
         end
      end
      kept_entries = survivors;

      err = clamp(desired - actual, -32768, 32767);

      // Rate and jerk against the oldest kept entry.
      if (kept_entries > 0) begin
         dt = ts - hist_stamp[0];
         if (dt <= 0) begin
            res.fault = 1'b1;
         end else begin
            rate = clamp((err - hist_err[0]) * 1000000 / dt, -64'sd2147483648, 64'sd2147483647);
            jerk = clamp((rate - hist_rate[0]) * 1000000 / dt, -64'sd2147483648,
                         64'sd2147483647);
         end
      end

      // Make room when full, then append the new entry.
      if (kept_entries >= HIST_DEPTH) begin
         for (int i = 0; i + 1 < HIST_DEPTH; i++) begin
            hist_stamp[i] = hist_stamp[i + 1];
            hist_err[i]   = hist_err[i + 1];
            hist_rate[i]  = hist_rate[i + 1];
         end
         kept_entries = HIST_DEPTH - 1;
      end
      hist_stamp[kept_entries] = ts;
      hist_err[kept_entries]   = err;
      hist_rate[kept_entries]  = rate;
      kept_entries++;

      // Correction decision outside the patience window.
      if (!(now - last_fix_us < patience) && magnitude(err) > err_thresh) begin
         zero_rate = magnitude(rate) < rate_thresh;
         helping   = (err < 0) != (rate < 0);
         if (zero_rate || !helping) begin
            prod    = gain_q15 * err;
            rounded = (magnitude(prod) + 16384) / 32768;
            res.amp  = ANGLE_W'(clamp((prod < 0) ? -rounded : rounded, -32768, 32767));
            res.send = 1'b1;
            last_fix_us = now;
         end
      end

      res.err  = ANGLE_W'(err);
      res.rate = RATE_W'(rate);
      res.jerk = RATE_W'(jerk);
      if (res.send) correction_count++;
      if (res.fault) fault_count++;
      awaited_steer.insert(awaited_steer.size(), res);
   endtask

   task automatic compare_result();
      steer_result_type want;
      if (awaited_steer.size() == 0) begin
         report_mismatch("unexpected result transfer", 1, 0);
      end else begin
         want = awaited_steer.pop_front();
         if (rsp.send_correction !== want.send)
            report_mismatch("send_correction", rsp.send_correction, want.send);
         if (rsp.amplitude !== want.amp)
            report_mismatch("amplitude", rsp.amplitude, want.amp);
         if (rsp.heading_error !== want.err)
            report_mismatch("heading_error", rsp.heading_error, want.err);
         if (rsp.error_rate !== want.rate)
            report_mismatch("error_rate", rsp.error_rate, want.rate);
         if (rsp.error_jerk !== want.jerk)
            report_mismatch("error_jerk", rsp.error_jerk, want.jerk);
         if (rsp.rate_fault !== want.fault)
            report_mismatch("rate_fault", rsp.rate_fault, want.fault);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         awaited_steer.delete();
         kept_entries     = 0;
         last_fix_us      = 0;
         gain_q15         = GAIN_RST;
         max_age          = MAX_AGE_RST;
         patience         = PATIENCE_RST;
         err_thresh       = ERR_THRESH_RST;
         rate_thresh      = RATE_THRESH_RST;
         fail_count       = 0;
         correction_count = 0;
         fault_count      = 0;
      end else begin
         // Register writes take effect at this edge.
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GAIN:        gain_q15    = csr_write_data[15:0];
               CSR_MAX_AGE:     max_age     = csr_write_data[23:0];
               CSR_PATIENCE:    patience    = csr_write_data[23:0];
               CSR_ERR_THRESH:  err_thresh  = csr_write_data[14:0];
               CSR_RATE_THRESH: rate_thresh = csr_write_data[30:0];
               default: ;
            endcase
         end
         // A result always belongs to an earlier sample, so compare first.
         if (rsp.valid && rsp.ready) compare_result();
         if (req.valid && req.ready) begin
            predict_heading(req.sample_time_us, req.now_us,
                            req.desired_azimuth, req.actual_azimuth);
         end
      end
      pending_results = awaited_steer.size();
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import scg_pkg::*;

   localparam int     NUM_PHASES  = 7;
   localparam int     PHASE_ITEMS = 255;
   localparam int     DRAIN_WAIT  = 250;
   localparam longint CYCLE_LIMIT = 3000000;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   csr_index_type        csr_index;
   logic [CSR_W-1:0]     csr_write_data;
   int                   fail_count;
   int                   pending_results;
   int                   correction_count;
   int                   fault_count;
   longint               cycle_count;
   longint               clock_us;
   bit                   calm;
   bit                   hold_request;
   int                   samples_sent;

   scg_req_if req_if ();
   scg_rsp_if rsp_if ();

   steering_correction_gate u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   scg_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_results  (pending_results),
      .correction_count (correction_count),
      .fault_count      (fault_count)
   );

   // Settings for each phase, extremes included.
   longint phase_gain     [NUM_PHASES] = '{5571, 65535, 0, 32768, 1, 40000, 5571};
   longint phase_max_age  [NUM_PHASES] = '{1000000, 16777215, 0, 5000, 300000, 1, 1000000};
   longint phase_patience [NUM_PHASES] = '{100000, 0, 16777215, 1000, 0, 50000, 100000};
   longint phase_err_th   [NUM_PHASES] = '{41, 0, 32767, 200, 1, 41, 41};
   longint phase_rate_th  [NUM_PHASES] = '{70, 2147483647, 0, 1000, 1, 70000, 70};
   int     phase_step_max [NUM_PHASES] = '{100000, 5000, 100, 2000, 40000, 20, 60000};

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Result side: random stalls, one long hold-off on request.
   initial begin
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_if.ready = 1'b0;
            repeat (800) @(negedge clock);
            hold_request = 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end else begin
            rsp_if.ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   // Offer one sample and hold it until the transfer; called at a falling edge.
   task automatic send_heading(input longint ts, input longint now,
                               input int desired, input int actual);
      req_if.valid           = 1'b1;
      req_if.sample_time_us  = TIME_W'(ts);
      req_if.now_us          = TIME_W'(now);
      req_if.desired_azimuth = ANGLE_W'(desired);
      req_if.actual_azimuth  = ANGLE_W'(actual);
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      samples_sent++;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input longint value);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = CSR_W'(value);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Wait until the block has delivered everything and gone quiet.
   task automatic settle();
      req_if.valid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // Mostly clean sample streams, with faults and noise mixed in.
   task automatic offer_random(input int step_max);
      int     pick;
      int     desired;
      int     spread;
      longint ts;
      pick    = $urandom_range(0, 99);
      desired = $signed(16'($urandom));
      spread  = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(0, 600);
      if (pick < 6) begin
         // Noise: arbitrary time stamp and angles.
         send_heading({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF, clock_us,
                      desired, $signed(16'($urandom)));
      end else if (pick < 12) begin
         // Stale or repeated time stamp.
         ts = clock_us - $urandom_range(0, 2000000);
         if (ts < 0) ts = 0;
         send_heading(ts, clock_us, desired, desired - $urandom_range(0, 2 * spread) + spread);
      end else begin
         clock_us += $urandom_range(1, step_max);
         send_heading(clock_us - $urandom_range(0, 3), clock_us + $urandom_range(0, 20),
                      desired, desired - $urandom_range(0, 2 * spread) + spread);
      end
   endtask

   initial begin
      req_if.valid           = 1'b0;
      req_if.sample_time_us  = '0;
      req_if.now_us          = '0;
      req_if.desired_azimuth = '0;
      req_if.actual_azimuth  = '0;
      csr_write_enable       = 1'b0;
      csr_index              = CSR_GAIN;
      csr_write_data         = '0;
      calm                   = 1'b0;
      hold_request           = 1'b0;
      samples_sent           = 0;
      clock_us               = 1000;
      reset                  = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed samples under the reset settings.
      send_heading(0, 0, 100, 0);                       // empty history
      send_heading(0, 0, 32767, -32768);                // positive saturation, zero dt
      send_heading(10, 200000, -32768, 32767);          // negative saturation, correction
      send_heading(20, 200010, 500, 500);               // zero error
      send_heading(5, 200020, -300, 0);                 // time stamp out of order
      send_heading(30, 200030, 32767, -32768);          // large rate, jerk overflow
      send_heading(31, 200040, -32768, 32767);          // jerk overflow
      send_heading(500000, 150000, 200, 0);             // entry after now, before last fix
      send_heading(600000, 700000, -200, 0);            // correction against rising rate
      send_heading(600100, 900000, 1000, 0);            // past patience, rate does not help
      send_heading(600200, 1100000, 50, 0);             // near threshold
      send_heading(2500000, 2500000, 41, 0);            // history aged out, error at threshold
      send_heading(2600000, 2700000, 42, 0);
      send_heading(2600001, 2800000, -42, 0);
      for (int i = 0; i < 18; i++)                      // fill and overflow the history
         send_heading(3000000 + i * 1000, 3000000 + i * 1000, i * 37 - 300, 0);
      send_heading(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1234, 1234);  // largest times
      send_heading(48'hFFFF_FFFF_FFFF, 0, 0, 0);
      send_heading(0, 48'hFFFF_FFFF_FFFF, -1, -1);
      clock_us = 4000000;

      // Random phases, each under its own settings.
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         write_reg(CSR_GAIN,        phase_gain[p]);
         write_reg(CSR_MAX_AGE,     phase_max_age[p]);
         write_reg(CSR_PATIENCE,    phase_patience[p]);
         write_reg(CSR_ERR_THRESH,  phase_err_th[p]);
         write_reg(CSR_RATE_THRESH, phase_rate_th[p]);
         if (p == 1) hold_request = 1'b1;
         if (p == NUM_PHASES - 1) calm = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) offer_random(phase_step_max[p]);
      end

      settle();
      $display("Sent %0d heading samples over %0d register settings.", samples_sent,
               NUM_PHASES + 1);
      $display("Saw %0d corrections and %0d rate faults.", correction_count, fault_count);
      if (fail_count == 0 && pending_results == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> steering_correction_gate.f
rtl/core/scg_pkg.sv
rtl/core/scg_req_if.sv
rtl/core/scg_rsp_if.sv
rtl/core/scg_div.sv
rtl/core/scg_dp.sv
rtl/core/scg_ctrl.sv
rtl/core/steering_correction_gate.sv
bench/scg_checker.sv
bench/tb_top.sv
